// File: rtl/label_majority_vote_top_assert.svh
// Assertion macros shared by the label majority vote RTL
`ifndef LABEL_MAJORITY_VOTE_TOP_ASSERT_SVH
`define LABEL_MAJORITY_VOTE_TOP_ASSERT_SVH

// same-cycle implication
`define LMV_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lmv assertion failed");

// next-cycle implication
`define LMV_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lmv assertion failed");

`endif

// File: rtl/lmv_pkg.sv
// Types, constants and helpers for the label majority vote block
package lmv_pkg;

  localparam int LABEL_W = 16;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic upd;      // a vote is in the update stage
    logic nonzero;  // that vote is not background
    logic hit;      // some cell holds the vote's label
    logic clear;    // voxel finished, empty the table
  } cell_ctrl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

// File: rtl/lmv_cell.sv
// One table cell: holds a distinct nonzero label and its vote count
module lmv_cell import lmv_pkg::*; #(
  parameter int LW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic [LW-1:0]      lab,
  input  logic               prev_valid,
  output logic               valid,
  output logic [COUNT_W-1:0] count,
  output logic               matched,
  output logic               touched
);

  logic [LW-1:0] entry_label;
  logic          claim;

  assign matched = valid && (entry_label == lab) && (lab != '0);
  // first empty cell takes a new label
  assign claim   = !valid && prev_valid && ctrl.nonzero && !ctrl.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      count   <= '0;
      touched <= 1'b0;
    end else if (ctrl.clear) begin
      valid   <= 1'b0;
      count   <= '0;
    end else if (ctrl.upd) begin
      touched <= matched || claim;
      if (matched) begin
        count <= sat_inc(count);
      end
      if (claim) begin
        valid <= 1'b1;
        count <= COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && claim) begin
      entry_label <= lab;
    end
  end

endmodule

// File: rtl/lmv_best.sv
// Background counter and running best label/count tracker
module lmv_best import lmv_pkg::*; #(
  parameter int LW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               clear,
  input  logic               bg,
  input  logic               hit,
  input  logic [LW-1:0]      lab,
  input  logic [COUNT_W-1:0] cell_count,
  output logic [LW-1:0]      best_label_next,
  output logic [COUNT_W-1:0] best_count_next
);

  logic [COUNT_W-1:0] background_count;
  logic [COUNT_W-1:0] bg_next;
  logic [LW-1:0]      best_label;
  logic [COUNT_W-1:0] best_count;
  logic [LW-1:0]      cand_label;
  logic [COUNT_W-1:0] cand_count;
  logic               better;

  always_comb begin
    bg_next    = sat_inc(background_count);
    cand_label = bg ? '0 : lab;
    cand_count = bg ? bg_next : cell_count;
    better     = (bg || hit) &&
                 ((cand_count > best_count) ||
                  ((cand_count == best_count) && (cand_label < best_label)));
    best_label_next = better ? cand_label : best_label;
    best_count_next = better ? cand_count : best_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      background_count <= '0;
      best_label       <= '0;
      best_count       <= '0;
    end else if (step) begin
      if (clear) begin
        background_count <= '0;
        best_label       <= '0;
        best_count       <= '0;
      end else begin
        if (bg) begin
          background_count <= bg_next;
        end
        best_label <= best_label_next;
        best_count <= best_count_next;
      end
    end
  end

endmodule

// File: rtl/label_majority_vote_top.sv
// A result word is registered onto m_axis when the tracker takes a voxel's last vote.
// Votes pass the vote register, the cell row update, then the best-label tracker reading
// the touched cell's count; no new vote is taken during the cell row update or a stall.
// Reset (synchronous, active high) empties the cell row, background count and best
// tracker, and drops any pending vote or result word.
module label_majority_vote_top import lmv_pkg::*; #(
  parameter int MAX_VOTERS = 16,
  parameter int LABEL_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [LABEL_W-1:0]   s_axis_tdata,   // [15:0] label
  input  logic                 s_axis_tlast,   // last_vote
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata    // [15:0] fused_label, [23:16] winning_votes
);

  `include "label_majority_vote_top_assert.svh"

  localparam int LW = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;

  logic               v1;
  logic               last1;
  logic [LW-1:0]      lab1;
  logic               v2;
  logic               last2;
  logic               bg2;
  logic [LW-1:0]      lab2;
  logic               stall;
  logic               step;
  logic               commit;
  logic               accept;
  cell_ctrl_t         ctrl;

  logic [MAX_VOTERS-1:0] valid_vec;
  logic [MAX_VOTERS-1:0] valid_inc;
  logic [MAX_VOTERS-1:0] match_vec;
  logic [MAX_VOTERS-1:0] touched_vec;
  logic [COUNT_W-1:0]    cnt [MAX_VOTERS];
  logic [COUNT_W-1:0]    sel_count;
  logic [LW-1:0]         best_label_next;
  logic [COUNT_W-1:0]    best_count_next;

  assign stall         = v2 && last2 && m_axis_tvalid && !m_axis_tready;
  assign step          = v2 && !stall;
  assign commit        = step && last2;
  assign s_axis_tready = !v1 && !stall;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1 || (v2 && stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lab1  <= s_axis_tdata[LW-1:0];
      last1 <= s_axis_tlast;
    end
    if (v1) begin
      lab2  <= lab1;
      last2 <= last1;
      bg2   <= (lab1 == '0);
    end
  end

  always_comb begin
    ctrl.upd     = v1;
    ctrl.nonzero = (lab1 != '0);
    ctrl.hit     = |match_vec;
    ctrl.clear   = commit;
  end

  for (genvar i = 0; i < MAX_VOTERS; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
    end
    lmv_cell #(.LW(LW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .lab        (lab1),
      .prev_valid (prev_valid),
      .valid      (valid_vec[i]),
      .count      (cnt[i]),
      .matched    (match_vec[i]),
      .touched    (touched_vec[i])
    );
  end

  always_comb begin
    sel_count = '0;
    for (int i = 0; i < MAX_VOTERS; i++) begin
      sel_count = sel_count | (touched_vec[i] ? cnt[i] : '0);
    end
  end

  lmv_best #(.LW(LW)) u_best (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .clear           (commit),
    .bg              (bg2),
    .hit             (|touched_vec),
    .lab             (lab2),
    .cell_count      (sel_count),
    .best_label_next (best_label_next),
    .best_count_next (best_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tdata <= {best_count_next, LABEL_W'(best_label_next)};
    end
  end

  assign valid_inc = valid_vec + MAX_VOTERS'(1);

  `LMV_ASSERT_IMP(a_one_cell_touched, clk, rst, v2, $onehot0(touched_vec))
  `LMV_ASSERT_IMP(a_stages_exclusive, clk, rst, 1'b1, !(v1 && v2))
  `LMV_ASSERT_IMP(a_table_packed, clk, rst, 1'b1, (valid_vec & valid_inc) == '0)
  `LMV_ASSERT_NXT(a_result_shown, clk, rst, commit, m_axis_tvalid)

endmodule
